// ===== rtl/core/aabbpo_pkg.sv =====
// Shared types and constants for the box pair overlap and penetration core.
package aabbpo_pkg;

	// Fixed result widths
	localparam int PEN_DEPTH_W = 25;
	localparam int AREA_W      = 52;

	// Clamp limits for depth and area
	localparam longint DEPTH_LIMIT = 64'sd16777215;
	localparam longint AREA_HI     = 64'sd2251799813685247;
	localparam longint AREA_LO     = -64'sd2251799813685248;

	// Penetration axis code
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

endpackage

// ===== rtl/core/aabbpo_pair_if.sv =====
// Input channel: one item is a pair of axis-aligned boxes.
interface aabbpo_pair_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_min_x;
	logic signed [COORD_BITS-1:0] a_min_y;
	logic signed [COORD_BITS-1:0] a_min_z;
	logic signed [COORD_BITS-1:0] a_max_x;
	logic signed [COORD_BITS-1:0] a_max_y;
	logic signed [COORD_BITS-1:0] a_max_z;
	logic signed [COORD_BITS-1:0] b_min_x;
	logic signed [COORD_BITS-1:0] b_min_y;
	logic signed [COORD_BITS-1:0] b_min_z;
	logic signed [COORD_BITS-1:0] b_max_x;
	logic signed [COORD_BITS-1:0] b_max_y;
	logic signed [COORD_BITS-1:0] b_max_z;

	modport source (
		output valid,
		input  ready,
		output a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
		output b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z
	);

	modport sink (
		input  valid,
		output ready,
		input  a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
		input  b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z
	);
endinterface

// ===== rtl/core/aabbpo_res_if.sv =====
// Result channel: overlap flag, penetration, union box and union area.
interface aabbpo_res_if
	import aabbpo_pkg::*;
#(
	parameter int COORD_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic                          overlap;
	axis_t                         pen_axis;
	logic signed [PEN_DEPTH_W-1:0] pen_depth;
	logic signed [COORD_BITS-1:0]  union_min_x;
	logic signed [COORD_BITS-1:0]  union_min_y;
	logic signed [COORD_BITS-1:0]  union_min_z;
	logic signed [COORD_BITS-1:0]  union_max_x;
	logic signed [COORD_BITS-1:0]  union_max_y;
	logic signed [COORD_BITS-1:0]  union_max_z;
	logic signed [AREA_W-1:0]      union_area;

	modport source (
		output valid,
		input  ready,
		output overlap, pen_axis, pen_depth,
		output union_min_x, union_min_y, union_min_z,
		output union_max_x, union_max_y, union_max_z,
		output union_area
	);

	modport sink (
		input  valid,
		output ready,
		input  overlap, pen_axis, pen_depth,
		input  union_min_x, union_min_y, union_min_z,
		input  union_max_x, union_max_y, union_max_z,
		input  union_area
	);
endinterface

// ===== rtl/core/aabbpo_axis.sv =====
// Per-axis slice: overlap test, signed depth, union bounds and union extent.
module aabbpo_axis #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] a_min,
	input  logic signed [COORD_BITS-1:0] a_max,
	input  logic signed [COORD_BITS-1:0] b_min,
	input  logic signed [COORD_BITS-1:0] b_max,
	output logic                         ov_s3,
	output logic signed [COORD_BITS:0]   dep_s3,
	output logic        [COORD_BITS:0]   mag_s3,
	output logic signed [COORD_BITS-1:0] umin_s3,
	output logic signed [COORD_BITS-1:0] umax_s3,
	output logic signed [COORD_BITS:0]   ext_s3
);
	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0]         p_s2;
	logic signed [DW-1:0]         q_s2;
	logic                         ov_s2;
	logic signed [COORD_BITS-1:0] umin_s2;
	logic signed [COORD_BITS-1:0] umax_s2;
	logic signed [DW-1:0]         dep;

	// p: how far A's max reaches past B's min; q: B's max past A's min
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= DW'(a_max) - DW'(b_min);
			q_s2    <= DW'(b_max) - DW'(a_min);
			ov_s2   <= (a_min < b_max) && (a_max > b_min);
			umin_s2 <= (a_min < b_min) ? a_min : b_min;
			umax_s2 <= (a_max > b_max) ? a_max : b_max;
		end
	end

	assign dep = (p_s2 <= q_s2) ? -p_s2 : q_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s3   <= ov_s2;
			dep_s3  <= dep;
			mag_s3  <= dep[DW-1] ? DW'(-dep) : DW'(dep);
			umin_s3 <= umin_s2;
			umax_s3 <= umax_s2;
			ext_s3  <= DW'(umax_s2) - DW'(umin_s2);
		end
	end

endmodule

// ===== rtl/core/aabb_pair_overlap_penetration_core.sv =====
// Top level of the box pair overlap, penetration and union area core.
//
// Takes one pair of axis-aligned boxes A and B per item (min and max corners,
// signed fixed point) and returns one result item: a strict overlap flag over
// all three axes, the axis of least penetration with its signed depth (given
// whether or not the boxes touch; equal magnitudes go to the later axis), the
// union box, and twice the sum of the union's face products as surface area
// with twice the coordinate's fractional bits. Depth is clamped to
// +-(2^24 - 1) and each area product, sum and the doubling to the signed
// 52-bit range; neither clamp can bite at 24-bit coordinates. Inverted boxes
// are not corrected and can give a negative area. The core is a six-register
// pipeline (input, two per-axis stages, multiply, first add, output) that
// accepts one item every cycle while it is not held; the result is shown from
// the output register. The whole pipeline holds while a shown result is not
// taken, so throughput is one item per cycle whenever the sink keeps up.
module aabb_pair_overlap_penetration_core
	import aabbpo_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	aabbpo_pair_if.sink   pair,
	aabbpo_res_if.source  res
);
	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	// wide enough for a product and for the area clamp limits
	localparam int XW = (PW > AREA_W) ? PW : AREA_W;
	// wide enough for a depth and for the depth clamp limits
	localparam int SW = (DW > PEN_DEPTH_W + 1) ? DW : PEN_DEPTH_W + 1;
	// area sums before clamping
	localparam int TW = AREA_W + 2;

	localparam logic signed [XW-1:0] PROD_HI  = XW'(AREA_HI);
	localparam logic signed [XW-1:0] PROD_LO  = XW'(AREA_LO);
	localparam logic signed [TW-1:0] SUM_HI   = TW'(AREA_HI);
	localparam logic signed [TW-1:0] SUM_LO   = TW'(AREA_LO);
	localparam logic signed [SW-1:0] DEPTH_HI = SW'(DEPTH_LIMIT);
	localparam logic signed [SW-1:0] DEPTH_LO = -SW'(DEPTH_LIMIT);

	// Handshake: every stage advances together when the output is free or taken
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, res_valid_q;

	// Stage 1: input register, one entry per axis
	logic signed [CW-1:0] amin_s1 [3];
	logic signed [CW-1:0] amax_s1 [3];
	logic signed [CW-1:0] bmin_s1 [3];
	logic signed [CW-1:0] bmax_s1 [3];

	// Stage 3: per-axis results
	logic                 ov_s3   [3];
	logic signed [DW-1:0] dep_s3  [3];
	logic        [DW-1:0] mag_s3  [3];
	logic signed [CW-1:0] umin_s3 [3];
	logic signed [CW-1:0] umax_s3 [3];
	logic signed [DW-1:0] ext_s3  [3];

	// Stage 4: axis choice, clamped depth, raw area products
	axis_t                         axis_sel;
	logic signed [DW-1:0]          dep_sel;
	logic signed [SW-1:0]          dep_wide;
	logic signed [PEN_DEPTH_W-1:0] dep_clamp;
	axis_t                         axis_s4;
	logic signed [PEN_DEPTH_W-1:0] depth_s4;
	logic                          ov_s4;
	logic signed [CW-1:0]          umin_s4 [3];
	logic signed [CW-1:0]          umax_s4 [3];
	logic signed [PW-1:0]          pxy_s4, pxz_s4, pyz_s4;

	// Stage 5: clamped partial sum
	logic signed [AREA_W-1:0]      sxy, sxz, syz;
	logic signed [TW-1:0]          sum_a;
	axis_t                         axis_s5;
	logic signed [PEN_DEPTH_W-1:0] depth_s5;
	logic                          ov_s5;
	logic signed [CW-1:0]          umin_s5 [3];
	logic signed [CW-1:0]          umax_s5 [3];
	logic signed [AREA_W-1:0]      part_s5;
	logic signed [AREA_W-1:0]      pyz_s5;

	// Output register
	logic signed [TW-1:0]          sum_b;
	logic signed [AREA_W-1:0]      sum_b_clamp;
	logic signed [TW-1:0]          dbl;
	logic                          overlap_q;
	axis_t                         pen_axis_q;
	logic signed [PEN_DEPTH_W-1:0] pen_depth_q;
	logic signed [CW-1:0]          umin_q [3];
	logic signed [CW-1:0]          umax_q [3];
	logic signed [AREA_W-1:0]      area_q;

	// Clamp a raw product to the signed area range
	function automatic logic signed [AREA_W-1:0] clamp_prod(input logic signed [PW-1:0] p);
		logic signed [XW-1:0] x;
		x = XW'(p);
		if (x > PROD_HI) begin
			x = PROD_HI;
		end else if (x < PROD_LO) begin
			x = PROD_LO;
		end
		return AREA_W'(x);
	endfunction

	// Clamp a widened sum to the signed area range
	function automatic logic signed [AREA_W-1:0] clamp_sum(input logic signed [TW-1:0] s);
		logic signed [TW-1:0] x;
		x = s;
		if (x > SUM_HI) begin
			x = SUM_HI;
		end else if (x < SUM_LO) begin
			x = SUM_LO;
		end
		return AREA_W'(x);
	endfunction

	assign adv        = !res_valid_q || res.ready;
	assign pair.ready = adv;

	// Valid chain; reset clears control only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pair.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			res_valid_q <= v_s5;
		end
	end

	// Stage 1: capture the pair
	always_ff @(posedge clk) begin
		if (adv) begin
			amin_s1[0] <= pair.a_min_x;
			amin_s1[1] <= pair.a_min_y;
			amin_s1[2] <= pair.a_min_z;
			amax_s1[0] <= pair.a_max_x;
			amax_s1[1] <= pair.a_max_y;
			amax_s1[2] <= pair.a_max_z;
			bmin_s1[0] <= pair.b_min_x;
			bmin_s1[1] <= pair.b_min_y;
			bmin_s1[2] <= pair.b_min_z;
			bmax_s1[0] <= pair.b_max_x;
			bmax_s1[1] <= pair.b_max_y;
			bmax_s1[2] <= pair.b_max_z;
		end
	end

	// Stages 2 and 3: one slice per axis
	for (genvar i = 0; i < 3; i++) begin : g_axis
		aabbpo_axis #(
			.COORD_BITS (COORD_BITS)
		) u_axis (
			.clk     (clk),
			.en      (adv),
			.a_min   (amin_s1[i]),
			.a_max   (amax_s1[i]),
			.b_min   (bmin_s1[i]),
			.b_max   (bmax_s1[i]),
			.ov_s3   (ov_s3[i]),
			.dep_s3  (dep_s3[i]),
			.mag_s3  (mag_s3[i]),
			.umin_s3 (umin_s3[i]),
			.umax_s3 (umax_s3[i]),
			.ext_s3  (ext_s3[i])
		);
	end

	// Stage 4: least penetration wins, ties go to the later axis
	always_comb begin
		if (mag_s3[0] < mag_s3[1] && mag_s3[0] < mag_s3[2]) begin
			axis_sel = AXIS_X;
		end else if (mag_s3[1] < mag_s3[2]) begin
			axis_sel = AXIS_Y;
		end else begin
			axis_sel = AXIS_Z;
		end

		case (axis_sel)
			AXIS_X:  dep_sel = dep_s3[0];
			AXIS_Y:  dep_sel = dep_s3[1];
			AXIS_Z:  dep_sel = dep_s3[2];
			default: dep_sel = dep_s3[2];
		endcase

		// clamp only matters for very wide coordinates
		dep_wide = SW'(dep_sel);
		if (dep_wide > DEPTH_HI) begin
			dep_wide = DEPTH_HI;
		end else if (dep_wide < DEPTH_LO) begin
			dep_wide = DEPTH_LO;
		end
		dep_clamp = PEN_DEPTH_W'(dep_wide);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			axis_s4  <= axis_sel;
			depth_s4 <= dep_clamp;
			ov_s4    <= ov_s3[0] && ov_s3[1] && ov_s3[2];
			umin_s4  <= umin_s3;
			umax_s4  <= umax_s3;
			pxy_s4   <= PW'(ext_s3[0]) * PW'(ext_s3[1]);
			pxz_s4   <= PW'(ext_s3[0]) * PW'(ext_s3[2]);
			pyz_s4   <= PW'(ext_s3[1]) * PW'(ext_s3[2]);
		end
	end

	// Stage 5: clamp products, add the first two
	assign sxy   = clamp_prod(pxy_s4);
	assign sxz   = clamp_prod(pxz_s4);
	assign syz   = clamp_prod(pyz_s4);
	assign sum_a = TW'(sxy) + TW'(sxz);

	always_ff @(posedge clk) begin
		if (adv) begin
			axis_s5  <= axis_s4;
			depth_s5 <= depth_s4;
			ov_s5    <= ov_s4;
			umin_s5  <= umin_s4;
			umax_s5  <= umax_s4;
			part_s5  <= clamp_sum(sum_a);
			pyz_s5   <= syz;
		end
	end

	// Output stage: add the third product, clamp, double, clamp again
	assign sum_b       = TW'(part_s5) + TW'(pyz_s5);
	assign sum_b_clamp = clamp_sum(sum_b);
	assign dbl         = TW'(sum_b_clamp) + TW'(sum_b_clamp);

	always_ff @(posedge clk) begin
		if (adv) begin
			overlap_q   <= ov_s5;
			pen_axis_q  <= axis_s5;
			pen_depth_q <= depth_s5;
			umin_q      <= umin_s5;
			umax_q      <= umax_s5;
			area_q      <= clamp_sum(dbl);
		end
	end

	// Drive the result channel from the output register
	assign res.valid       = res_valid_q;
	assign res.overlap     = overlap_q;
	assign res.pen_axis    = pen_axis_q;
	assign res.pen_depth   = pen_depth_q;
	assign res.union_min_x = umin_q[0];
	assign res.union_min_y = umin_q[1];
	assign res.union_min_z = umin_q[2];
	assign res.union_max_x = umax_q[0];
	assign res.union_max_y = umax_q[1];
	assign res.union_max_z = umax_q[2];
	assign res.union_area  = area_q;

endmodule

// ===== tb/sv/aabb_pair_overlap_penetration_checker.sv =====
// Watches both channels of the box pair core, works out each result and compares it.
module aabb_pair_overlap_penetration_checker
	import aabbpo_pkg::*;
#(
	parameter int COORD_W = 24
) (
	input  logic   clk,
	input  logic   arst_n,
	aabbpo_pair_if pair,
	aabbpo_res_if  res,
	output int     failures,
	output int     pending,
	output int     checked
);

	localparam int SHOWN_LIMIT = 30;

	typedef longint triple_t [3];

	typedef struct packed {
		logic                          overlap;
		axis_t                         axis;
		logic signed [PEN_DEPTH_W-1:0] depth;
		logic [2:0][COORD_W-1:0]       lo;
		logic [2:0][COORD_W-1:0]       hi;
		logic signed [AREA_W-1:0]      area;
	} box_outcome_t;

	box_outcome_t expected_outcomes [$];
	int           fail_count = 0;
	int           result_count = 0;

	assign failures = fail_count;
	assign checked  = result_count;

	task automatic report_mismatch(input string field, input longint got, input longint want);
		fail_count++;
		if (fail_count <= SHOWN_LIMIT)
			$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
	endtask

	function automatic longint clamp_area(input longint v);
		if (v > AREA_HI)
			return AREA_HI;
		if (v < AREA_LO)
			return AREA_LO;
		return v;
	endfunction

	// Overlap flag, least penetration, union box and union surface area of one pair.
	function automatic box_outcome_t predict_overlap(input triple_t amin, input triple_t amax,
			input triple_t bmin, input triple_t bmax);
		box_outcome_t o;
		longint       dep [3];
		longint       mg [3];
		longint       ext [3];
		longint       lo, hi, p, q, depth, area;
		o.overlap = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (!(amin[k] < bmax[k] && amax[k] > bmin[k]))
				o.overlap = 1'b0;
			p = amax[k] - bmin[k];
			q = bmax[k] - amin[k];
			dep[k] = (p <= q) ? -p : q;
			mg[k] = (dep[k] < 0) ? -dep[k] : dep[k];
			lo = (amin[k] < bmin[k]) ? amin[k] : bmin[k];
			hi = (amax[k] > bmax[k]) ? amax[k] : bmax[k];
			ext[k] = hi - lo;
			o.lo[k] = lo[COORD_W-1:0];
			o.hi[k] = hi[COORD_W-1:0];
		end
		// ties go to the later axis
		if (mg[0] < mg[1] && mg[0] < mg[2])
			o.axis = AXIS_X;
		else if (mg[1] < mg[2])
			o.axis = AXIS_Y;
		else
			o.axis = AXIS_Z;
		depth = dep[o.axis];
		if (depth > DEPTH_LIMIT)
			depth = DEPTH_LIMIT;
		if (depth < -DEPTH_LIMIT)
			depth = -DEPTH_LIMIT;
		o.depth = depth[PEN_DEPTH_W-1:0];
		area = clamp_area(clamp_area(ext[0] * ext[1]) + clamp_area(ext[0] * ext[2]));
		area = clamp_area(area + clamp_area(ext[1] * ext[2]));
		area = clamp_area(area * 2);
		o.area = area[AREA_W-1:0];
		return o;
	endfunction

	always @(posedge clk) begin : watch
		triple_t      amin, amax, bmin, bmax;
		box_outcome_t want;
		if (arst_n) begin
			// take results before new pairs: a pair cannot come out at the edge it goes in
			if (res.valid && res.ready) begin
				result_count++;
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with nothing expected", res.union_area, 0);
				end else begin
					want = expected_outcomes.pop_front();
					if (res.overlap !== want.overlap)
						report_mismatch("overlap", res.overlap, want.overlap);
					if (res.pen_axis !== want.axis)
						report_mismatch("pen_axis", res.pen_axis, want.axis);
					if (res.pen_depth !== want.depth)
						report_mismatch("pen_depth", res.pen_depth, want.depth);
					if (res.union_min_x !== want.lo[0])
						report_mismatch("union_min_x", res.union_min_x, $signed(want.lo[0]));
					if (res.union_min_y !== want.lo[1])
						report_mismatch("union_min_y", res.union_min_y, $signed(want.lo[1]));
					if (res.union_min_z !== want.lo[2])
						report_mismatch("union_min_z", res.union_min_z, $signed(want.lo[2]));
					if (res.union_max_x !== want.hi[0])
						report_mismatch("union_max_x", res.union_max_x, $signed(want.hi[0]));
					if (res.union_max_y !== want.hi[1])
						report_mismatch("union_max_y", res.union_max_y, $signed(want.hi[1]));
					if (res.union_max_z !== want.hi[2])
						report_mismatch("union_max_z", res.union_max_z, $signed(want.hi[2]));
					if (res.union_area !== want.area)
						report_mismatch("union_area", res.union_area, want.area);
				end
			end
			if (pair.valid && pair.ready) begin
				amin = '{pair.a_min_x, pair.a_min_y, pair.a_min_z};
				amax = '{pair.a_max_x, pair.a_max_y, pair.a_max_z};
				bmin = '{pair.b_min_x, pair.b_min_y, pair.b_min_z};
				bmax = '{pair.b_max_x, pair.b_max_y, pair.b_max_z};
				expected_outcomes.push_back(predict_overlap(amin, amax, bmin, bmax));
			end
		end
		pending <= expected_outcomes.size();
	end

endmodule

// ===== tb/sv/aabb_pair_overlap_penetration_core_tb.sv =====
// Top of the box pair core testbench: clock, reset, pair stimulus, sink stalls and verdict.
module aabb_pair_overlap_penetration_core_tb;
	import aabbpo_pkg::*;

	localparam int COORD_W      = 24;
	localparam int UNIT         = 4096;      // 1.0 in 12 fractional bits
	localparam int C_MIN        = -8388608;
	localparam int C_MAX        = 8388607;
	localparam int RANDOM_PAIRS = 1400;
	localparam int IDLE_PCT     = 7;
	localparam int DRAIN_CYCLES = 12;        // six-stage pipeline, with margin

	// One box: lo and hi corners, index 0 x, 1 y, 2 z
	typedef struct packed {
		logic [2:0][COORD_W-1:0] lo;
		logic [2:0][COORD_W-1:0] hi;
	} box_t;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   sent;
	int   directed;
	int   failures, pending, checked;

	aabbpo_pair_if #(.COORD_BITS(COORD_W)) pair_ch ();
	aabbpo_res_if  #(.COORD_BITS(COORD_W)) res_ch ();

	aabb_pair_overlap_penetration_core #(
		.COORD_BITS(COORD_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.res    (res_ch)
	);

	aabb_pair_overlap_penetration_checker #(
		.COORD_W(COORD_W)
	) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair_ch),
		.res      (res_ch),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop: far beyond the slowest correct run of 1416 pairs with stalls.
	initial begin
		#4000000;
		$display("aabb_pair_overlap_penetration_core test failed");
		$finish;
	end

	// Sink side: stall now and then, never during the steady stretch.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic box_t make_box(input int lx, input int ly, input int lz,
			input int hx, input int hy, input int hz);
		box_t b;
		b.lo = {COORD_W'(lz), COORD_W'(ly), COORD_W'(lx)};
		b.hi = {COORD_W'(hz), COORD_W'(hy), COORD_W'(hx)};
		return b;
	endfunction

	// Extreme or boundary value of one coordinate, now and then a random one
	function automatic logic [COORD_W-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return COORD_W'(C_MIN);
			1: return COORD_W'(C_MAX);
			2: return '1;
			3: return '0;
			4: return COORD_W'(1);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic int signed_pick(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Present one pair, idling first at random; hold it until the core takes it.
	task automatic send_pair(input box_t a, input box_t b);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid   <= 1'b1;
		pair_ch.a_min_x <= a.lo[0];
		pair_ch.a_min_y <= a.lo[1];
		pair_ch.a_min_z <= a.lo[2];
		pair_ch.a_max_x <= a.hi[0];
		pair_ch.a_max_y <= a.hi[1];
		pair_ch.a_max_z <= a.hi[2];
		pair_ch.b_min_x <= b.lo[0];
		pair_ch.b_min_y <= b.lo[1];
		pair_ch.b_min_z <= b.lo[2];
		pair_ch.b_max_x <= b.hi[0];
		pair_ch.b_max_y <= b.hi[1];
		pair_ch.b_max_z <= b.hi[2];
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Random pair: mostly neighbouring well-formed boxes, then coarse grid boxes
	// (ties, touching faces, inversions), raw random words and boundary values.
	task automatic random_pair(output box_t a, output box_t b);
		int kind, c, ha, hb, off;
		kind = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			if (kind < 55) begin
				c   = signed_pick(1 << 22);
				ha  = $urandom_range(0, 1 << 18);
				hb  = $urandom_range(0, 1 << 18);
				off = signed_pick(1 << 19);
				a.lo[k] = COORD_W'(c - ha);
				a.hi[k] = COORD_W'(c + ha);
				b.lo[k] = COORD_W'(c + off - hb);
				b.hi[k] = COORD_W'(c + off + hb);
			end else if (kind < 65) begin
				a.lo[k] = COORD_W'(signed_pick(3) * UNIT);
				a.hi[k] = COORD_W'(signed_pick(3) * UNIT);
				b.lo[k] = COORD_W'(signed_pick(3) * UNIT);
				b.hi[k] = COORD_W'(signed_pick(3) * UNIT);
			end else if (kind < 85) begin
				a.lo[k] = COORD_W'($urandom);
				a.hi[k] = COORD_W'($urandom);
				b.lo[k] = COORD_W'($urandom);
				b.hi[k] = COORD_W'($urandom);
			end else begin
				a.lo[k] = edge_coord();
				a.hi[k] = edge_coord();
				b.lo[k] = edge_coord();
				b.hi[k] = edge_coord();
			end
		end
	endtask

	initial begin
		box_t a, b;
		arst_n        = 1'b0;
		steady        = 1'b0;
		sent          = 0;
		pair_ch.valid = 1'b0;
		{pair_ch.a_min_x, pair_ch.a_min_y, pair_ch.a_min_z} = '0;
		{pair_ch.a_max_x, pair_ch.a_max_y, pair_ch.a_max_z} = '0;
		{pair_ch.b_min_x, pair_ch.b_min_y, pair_ch.b_min_z} = '0;
		{pair_ch.b_max_x, pair_ch.b_max_y, pair_ch.b_max_z} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs
		// all zero
		send_pair(make_box(0, 0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0, 0));
		// equal depth on every axis: z wins the three-way tie
		send_pair(make_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT),
			make_box(0, 0, 0, 2 * UNIT, 2 * UNIT, 2 * UNIT));
		// x strictly least
		send_pair(make_box(0, 0, 0, 4 * UNIT, 4 * UNIT, 4 * UNIT),
			make_box(7 * UNIT / 2, 2 * UNIT, UNIT, 8 * UNIT, 8 * UNIT, 8 * UNIT));
		// y strictly least
		send_pair(make_box(0, 0, 0, 4 * UNIT, 4 * UNIT, 4 * UNIT),
			make_box(2 * UNIT, 3 * UNIT, UNIT, 8 * UNIT, 8 * UNIT, 8 * UNIT));
		// x and y tie below z: y wins
		send_pair(make_box(0, 0, 0, 4 * UNIT, 4 * UNIT, 4 * UNIT),
			make_box(3 * UNIT, 3 * UNIT, UNIT, 8 * UNIT, 8 * UNIT, 8 * UNIT));
		// x and z tie below y: z wins
		send_pair(make_box(0, 0, 0, 4 * UNIT, 4 * UNIT, 4 * UNIT),
			make_box(3 * UNIT, UNIT, 3 * UNIT, 8 * UNIT, 8 * UNIT, 8 * UNIT));
		// B overlaps A from below: positive depth, x least
		send_pair(make_box(2 * UNIT, 2 * UNIT, 2 * UNIT, 6 * UNIT, 6 * UNIT, 6 * UNIT),
			make_box(0, 0, 0, 3 * UNIT, 4 * UNIT, 5 * UNIT));
		// disjoint boxes still report a penetration
		send_pair(make_box(0, 0, 0, UNIT, UNIT, UNIT),
			make_box(5 * UNIT, 5 * UNIT, 5 * UNIT, 6 * UNIT, 6 * UNIT, 6 * UNIT));
		// faces touching on x only: not a strict overlap
		send_pair(make_box(0, 0, 0, UNIT, 2 * UNIT, 2 * UNIT),
			make_box(UNIT, UNIT, UNIT, 2 * UNIT, 3 * UNIT, 3 * UNIT));
		// both boxes span the full range
		send_pair(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX),
			make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		// degenerate at opposite ends: largest positive and negative depths
		send_pair(make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN),
			make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
		send_pair(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX),
			make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
		// fully inverted boxes: negative extents, positive area
		send_pair(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN),
			make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
		// inverted on x alone: negative area
		send_pair(make_box(3 * UNIT, -UNIT, -UNIT, -3 * UNIT, UNIT, UNIT),
			make_box(2 * UNIT, 0, 0, -2 * UNIT, 2 * UNIT, 2 * UNIT));
		// one-LSB boxes around zero
		send_pair(make_box(-1, -1, -1, 1, 1, 1), make_box(0, 0, 0, 0, 0, 0));
		// thin boxes at opposite corners of the range
		send_pair(make_box(C_MIN, C_MIN, C_MIN, C_MIN + 1, C_MIN + 1, C_MIN + 1),
			make_box(C_MAX - 1, C_MAX - 1, C_MAX - 1, C_MAX, C_MAX, C_MAX));
		directed = sent;

		// Random pairs, with a stretch where neither side idles
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			steady <= (n >= 500 && n < 800);
			random_pair(a, b);
			send_pair(a, b);
		end
		pair_ch.valid <= 1'b0;
		// let the checker count the last pair before looking at the backlog
		@(posedge clk);

		// Drain: wait for every expected result, then let the pipeline run dry
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d box pairs (%0d directed, rest random) under source and sink stalls",
			sent, directed);
		$display("Checked %0d results field by field, %0d mismatches", checked, failures);
		if (failures == 0) begin
			$display("aabb_pair_overlap_penetration_core test passed");
		end else begin
			$display("aabb_pair_overlap_penetration_core test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/aabbpo_pkg.sv
rtl/core/aabbpo_pair_if.sv
rtl/core/aabbpo_res_if.sv
rtl/core/aabbpo_axis.sv
rtl/core/aabb_pair_overlap_penetration_core.sv
tb/sv/aabb_pair_overlap_penetration_checker.sv
tb/sv/aabb_pair_overlap_penetration_core_tb.sv
